### src/positional_list_insert_delete_core_defines.svh
// ----------------------------------------------------------------------------
// Positional list core assertion macros
// Clocked property checks with and without a reset disable.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks prop at every rising edge of clk while rst_n is high.
`define PLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks prop at every rising edge of clk, reset included.
`define PLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PLM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

### src/plm_pkg.sv
// ----------------------------------------------------------------------------
// Positional list package
// Sizes, action and status codes, and beat types shared by the list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plm_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int ITEM_WIDTH = 32;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int GROUP      = 8;
    localparam int NGROUP     = LIST_DEPTH / GROUP;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_PEEK   = 2'd2;
    localparam logic [1:0] ACT_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef logic [ITEM_WIDTH-1:0] t_item;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  position;
        logic [31:0] item_data;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] item_out;
        logic [1:0]  status;
        logic [6:0]  entry_count;
        logic        is_full;
        logic        is_empty;
    } t_out_beat;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             read_en;
        logic [IDX_W-1:0] pos;
        t_item            data;
    } t_cell_ctrl;

endpackage

### src/plm_cell.sv
// ----------------------------------------------------------------------------
// Positional list cell
// Holds one list entry and shifts it from or to its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plm_cell
    import plm_pkg::*;
(
    input  logic             i_clk,
    input  logic [IDX_W-1:0] i_index,
    input  t_cell_ctrl       i_ctrl,
    input  t_item            i_left,
    input  t_item            i_right,
    output t_item            o_value,
    output t_item            o_tap
);

    t_item r_value;
    t_item n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.shift_up) begin
            if (i_index > i_ctrl.pos) begin
                n_value = i_left;
            end else if (i_index == i_ctrl.pos) begin
                n_value = i_ctrl.data;
            end
        end else if (i_ctrl.shift_down) begin
            // Cells past the new end take stale data; they are never read.
            if (i_index >= i_ctrl.pos) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_tap   = (i_ctrl.read_en && (i_index == i_ctrl.pos)) ? r_value : '0;

endmodule

### src/plm_read_tree.sv
// ----------------------------------------------------------------------------
// Positional list read tree
// Two-level OR of the cell taps with a registered first level; at most one tap is nonzero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plm_read_tree
    import plm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_load,
    input  t_item i_taps [LIST_DEPTH],
    output t_item o_word
);

    t_item r_part [NGROUP];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int g = 0; g < NGROUP; g++) begin
                r_part[g] <= i_taps[g*GROUP]   | i_taps[g*GROUP+1] |
                             i_taps[g*GROUP+2] | i_taps[g*GROUP+3] |
                             i_taps[g*GROUP+4] | i_taps[g*GROUP+5] |
                             i_taps[g*GROUP+6] | i_taps[g*GROUP+7];
            end
        end
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < NGROUP; g++) begin
            o_word = o_word | r_part[g];
        end
    end

endmodule

### src/positional_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// Positional list insert/delete core
// Bounded ordered list held in a chain of cells, addressed by position.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-----------
//   in      | input     | i_in_valid / o_in_stall   | t_in_beat
//   out     | output    | o_out_valid / i_out_stall | t_out_beat
//
// Each beat passes through accept, cell update with the first read-tree
// level, then the final OR into the output register.
// One beat is in flight at a time; a new beat is accepted while the previous
// result still waits in the output register.
// A stalled output holds the next result in the read tree until it drains.
// Reset clears the count and the control state; cell contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_insert_delete_core_defines.svh"

module positional_list_insert_delete_core
    import plm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_COLLECT = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_count;
    t_cell_ctrl       r_ctrl;
    logic [1:0]       r_status;
    logic             r_out_valid;
    t_out_beat        r_out_beat;

    logic             in_accept;
    logic             out_free;
    logic [CNT_W-1:0] pos_ext;
    logic             is_full_now;
    t_cell_ctrl       n_ctrl;
    logic [1:0]       n_status;
    logic [CNT_W-1:0] n_count;
    t_cell_ctrl       cell_ctrl;
    t_item            cell_value [LIST_DEPTH];
    t_item            cell_tap   [LIST_DEPTH];
    t_item            read_word;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign pos_ext     = CNT_W'(i_in_beat.position);
    assign is_full_now = (r_count == CNT_W'(LIST_DEPTH));

    always_comb begin
        n_ctrl            = '0;
        n_ctrl.data       = i_in_beat.item_data[ITEM_WIDTH-1:0];
        n_status          = ST_OK;
        n_count           = r_count;
        unique case (i_in_beat.action)
            ACT_INSERT: begin
                if (is_full_now) begin
                    n_status = ST_FULL;
                end else begin
                    n_ctrl.shift_up = 1'b1;
                    n_ctrl.pos      = (pos_ext > r_count) ? IDX_W'(r_count) : IDX_W'(pos_ext);
                    n_count         = r_count + CNT_W'(1);
                end
            end
            ACT_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ctrl.shift_down = 1'b1;
                    n_ctrl.read_en    = 1'b1;
                    n_ctrl.pos        = (pos_ext >= r_count) ? IDX_W'(r_count - CNT_W'(1))
                                                             : IDX_W'(pos_ext);
                    n_count           = r_count - CNT_W'(1);
                end
            end
            ACT_PEEK: begin
                if (pos_ext >= r_count) begin
                    n_status = ST_RANGE;
                end else begin
                    n_ctrl.read_en = 1'b1;
                    n_ctrl.pos     = IDX_W'(pos_ext);
                end
            end
            default: begin
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ctrl      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_COLLECT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_ctrl  <= n_ctrl;
                        r_count <= n_count;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_COLLECT;
                end
                S_COLLECT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_status <= n_status;
        end
        if ((r_state == S_COLLECT) && out_free) begin
            r_out_beat.item_out    <= 32'(read_word);
            r_out_beat.status      <= r_status;
            r_out_beat.entry_count <= 7'(r_count);
            r_out_beat.is_full     <= (r_count == CNT_W'(LIST_DEPTH));
            r_out_beat.is_empty    <= (r_count == '0);
        end
    end

    // Cells move only in the update cycle; the tap select stays live for the tree.
    always_comb begin
        cell_ctrl            = r_ctrl;
        cell_ctrl.shift_up   = r_ctrl.shift_up && (r_state == S_EXEC);
        cell_ctrl.shift_down = r_ctrl.shift_down && (r_state == S_EXEC);
    end

    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        t_item left_value;
        t_item right_value;

        if (g == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_mid_left
            assign left_value = cell_value[g-1];
        end

        if (g == LIST_DEPTH - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_mid_right
            assign right_value = cell_value[g+1];
        end

        plm_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(g)),
            .i_ctrl  (cell_ctrl),
            .i_left  (left_value),
            .i_right (right_value),
            .o_value (cell_value[g]),
            .o_tap   (cell_tap[g])
        );
    end

    plm_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_load (r_state == S_EXEC),
        .i_taps (cell_tap),
        .o_word (read_word)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    `PLM_ASSERT(a_accept_to_exec, i_clk, i_rst_n, in_accept |=> (r_state == S_EXEC), "accepted beat did not start the cell update")
    `PLM_ASSERT(a_exec_to_collect, i_clk, i_rst_n, (r_state == S_EXEC) |=> (r_state == S_COLLECT), "cell update did not move to collect")
    `PLM_ASSERT_ALWAYS(a_count_bound, i_clk, !i_rst_n || (r_count <= CNT_W'(LIST_DEPTH)), "entry count exceeds list depth")
    `PLM_ASSERT(a_result_from_collect, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == S_COLLECT), "result raised outside collect")

endmodule

### tb/positional_list_checker.sv
// ----------------------------------------------------------------------------
// Positional list checker
// Watches both channels of the list core, predicts each result from its own
// copy of the list and compares every output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_checker
    import plm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_beat,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_beat,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_checked,
    output int        o_rejected_full,
    output int        o_range_flags
);

    t_item     list_words [LIST_DEPTH];
    int        list_len;
    t_out_beat awaited_q [$];
    t_out_beat oldest;
    int        fail_count;
    int        checked;
    int        rejected_full;
    int        range_flags;

    assign o_fail_count    = fail_count;
    assign o_pending       = awaited_q.size();
    assign o_checked       = checked;
    assign o_rejected_full = rejected_full;
    assign o_range_flags   = range_flags;

    initial begin
        list_len      = 0;
        fail_count    = 0;
        checked       = 0;
        rejected_full = 0;
        range_flags   = 0;
    end

    // Applies one operation to the shadow list and returns the result it gives.
    function automatic t_out_beat apply_list_op(t_in_beat op);
        t_out_beat res;
        t_item     word;
        int        slot;
        int        i;
        res  = '0;
        word = '0;
        slot = op.position;
        res.status = ST_OK;
        case (op.action)
            ACT_INSERT: begin
                if (list_len >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    if (slot > list_len) slot = list_len;
                    for (i = list_len; i > slot; i--) list_words[i] = list_words[i-1];
                    list_words[slot] = op.item_data[ITEM_WIDTH-1:0];
                    list_len++;
                end
            end
            ACT_DELETE: begin
                if (list_len == 0) begin
                    res.status = ST_RANGE;
                end else begin
                    if (slot >= list_len) slot = list_len - 1;
                    word = list_words[slot];
                    for (i = slot; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
                    list_len--;
                end
            end
            ACT_PEEK: begin
                if (slot >= list_len) res.status = ST_RANGE;
                else word = list_words[slot];
            end
            ACT_CLEAR: begin
                list_len = 0;
            end
        endcase
        res.item_out    = word;
        res.entry_count = list_len[6:0];
        res.is_full     = (list_len == LIST_DEPTH);
        res.is_empty    = (list_len == 0);
        return res;
    endfunction

    task automatic check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_len = 0;
            awaited_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) awaited_q.push_back(apply_list_op(i_in_beat));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with nothing expected, expected none, got 0x%0h",
                             $time, i_out_beat);
                end else begin
                    oldest = awaited_q.pop_front();
                    checked++;
                    if (oldest.status == ST_FULL) rejected_full++;
                    if (oldest.status == ST_RANGE) range_flags++;
                    check_field("item_out", oldest.item_out, i_out_beat.item_out);
                    check_field("status", 32'(oldest.status), 32'(i_out_beat.status));
                    check_field("entry_count", 32'(oldest.entry_count),
                                32'(i_out_beat.entry_count));
                    check_field("is_full", 32'(oldest.is_full), 32'(i_out_beat.is_full));
                    check_field("is_empty", 32'(oldest.is_empty), 32'(i_out_beat.is_empty));
                end
            end
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Positional list core testbench
// Drives directed and phased random list operations with random gaps and
// stalls, including one long output hold, and reports the checker verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import plm_pkg::*;

    localparam int RANDOM_ITEMS = 1450;
    localparam int HOLD_CYCLES  = 250;
    localparam int IDLE_LIMIT   = 2000;

    typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} t_phase;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    int fail_count;
    int pending;
    int checked;
    int rejected_full;
    int range_flags;
    int op_tally [4];
    bit send_burst;

    positional_list_insert_delete_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    positional_list_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_in_beat       (in_beat),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_out_beat      (out_beat),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_rejected_full (rejected_full),
        .o_range_flags   (range_flags)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one beat after a random gap and holds it until it is taken.
    task automatic offer_beat(logic [1:0] act, logic [5:0] pos, logic [31:0] word);
        t_in_beat beat;
        int       gap;
        beat.action    = act;
        beat.position  = pos;
        beat.item_data = word;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge clk); while (!(in_valid && !in_stall));
        op_tally[act]++;
    endtask

    // Stimulus and verdict.
    initial begin
        int         sent;
        int         phase;
        int         phase_len;
        int         pick;
        t_phase     kind;
        logic [1:0] act;
        logic [5:0] pos;
        sent = 0;
        phase = 0;
        send_burst = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Empty list, append past the end, middle inserts, reads and removals.
        offer_beat(ACT_PEEK, 6'd0, 32'h1234_5678);
        offer_beat(ACT_DELETE, 6'd5, 32'h0);
        offer_beat(ACT_INSERT, 6'd0, 32'hFFFF_FFFF);
        offer_beat(ACT_INSERT, 6'd63, 32'h0000_0000);
        offer_beat(ACT_INSERT, 6'd0, 32'hA5A5_A5A5);
        offer_beat(ACT_INSERT, 6'd1, 32'h5A5A_5A5A);
        offer_beat(ACT_PEEK, 6'd0, 32'hFFFF_FFFF);
        offer_beat(ACT_PEEK, 6'd3, 32'h0);
        offer_beat(ACT_PEEK, 6'd4, 32'h0);
        offer_beat(ACT_PEEK, 6'd63, 32'h0);
        offer_beat(ACT_DELETE, 6'd1, 32'h0);
        offer_beat(ACT_DELETE, 6'd63, 32'h0);
        offer_beat(ACT_INSERT, 6'd2, $urandom);
        offer_beat(ACT_INSERT, 6'd42, $urandom);
        offer_beat(ACT_CLEAR, 6'd17, 32'hDEAD_BEEF);
        offer_beat(ACT_PEEK, 6'd0, 32'h0);
        offer_beat(ACT_DELETE, 6'd0, 32'h0);
        offer_beat(ACT_INSERT, 6'd0, $urandom);
        offer_beat(ACT_DELETE, 6'd0, 32'h0);
        offer_beat(ACT_CLEAR, 6'd0, 32'h0);

        // Grow phases fill the list past full, shrink phases drain it past empty.
        while (sent < RANDOM_ITEMS) begin
            kind = t_phase'(phase % 3);
            phase_len = (kind == PH_GROW) ? $urandom_range(110, 180) : $urandom_range(60, 140);
            send_burst = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                if (kind == PH_GROW) begin
                    act = (pick < 72) ? ACT_INSERT : (pick < 90) ? ACT_PEEK : ACT_DELETE;
                end else if (kind == PH_SHRINK) begin
                    act = (pick < 70) ? ACT_DELETE : (pick < 88) ? ACT_PEEK : ACT_INSERT;
                end else begin
                    act = (pick < 40) ? ACT_INSERT : (pick < 70) ? ACT_DELETE :
                          (pick < 97) ? ACT_PEEK : ACT_CLEAR;
                end
                case ($urandom_range(0, 3))
                    0: pos = 6'd0;
                    1: pos = 6'd63;
                    2: pos = 6'($urandom_range(0, 7));
                    default: pos = 6'($urandom_range(0, 63));
                endcase
                offer_beat(act, pos, $urandom);
                sent++;
            end
            phase++;
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("Ran %0d list operations: %0d inserts, %0d deletes, %0d peeks, %0d clears.",
                 op_tally[0] + op_tally[1] + op_tally[2] + op_tally[3],
                 op_tally[ACT_INSERT], op_tally[ACT_DELETE], op_tally[ACT_PEEK],
                 op_tally[ACT_CLEAR]);
        $display("Compared %0d results, %0d inserts rejected on a full list, %0d range flags.",
                 checked, rejected_full, range_flags);
        if (fail_count == 0) begin
            $display("positional_list_insert_delete_core verification clean");
        end else begin
            $display("positional_list_insert_delete_core verification failed");
        end
        $finish;
    end

    // Result side: random stalls per beat, unstalled stretches, and one long
    // hold so that the core fills up and stalls its input.
    initial begin
        int wait_cycles;
        int taken;
        bit rx_burst;
        bit hold_done;
        taken = 0;
        rx_burst = 1'b0;
        hold_done = 1'b0;
        repeat (2) @(posedge clk);
        forever begin
            if (taken % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
            if (!hold_done && taken == 300) begin
                wait_cycles = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                wait_cycles = rx_burst ? 0 : $urandom_range(0, 4);
            end
            if (wait_cycles != 0) begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
            taken++;
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("Timeout: no beat accepted for %0d cycles.", IDLE_LIMIT);
        $display("positional_list_insert_delete_core verification failed");
        $finish;
    end

endmodule
